[rtl/core/bfr_pkg.sv]
// ============================================================================
// bfr_pkg: shared constants and tables of the bilateral filter
// Store geometry, fixed-point widths, luma weights, the square-root table of
// the tap distances and the fractional power-of-two table of the weight unit.
// ============================================================================
`default_nettype none

package bfr_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_KERNEL  = 7;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_KERNEL;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int SLOT_W      = $clog2(MAX_KERNEL);
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int OUT_CAP     = 4;

    // weight sum of up to 49 taps of at most 1.0 in Q1.16, and channel sums
    localparam int WS_W   = 22;
    localparam int SUM_W  = 30;
    localparam int DIST_W = 19;

    localparam logic [16:0] LUMA_R    = 17'd19595;
    localparam logic [16:0] LUMA_G    = 17'd38470;
    localparam logic [16:0] LUMA_B    = 17'd7471;
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;

    localparam logic [2:0] CFG_WIDTH   = 3'd0;
    localparam logic [2:0] CFG_HEIGHT  = 3'd1;
    localparam logic [2:0] CFG_KERNEL  = 3'd2;
    localparam logic [2:0] CFG_RANGE   = 3'd3;
    localparam logic [2:0] CFG_SPATIAL = 3'd4;

    // 2^-(2^(b-8)) in Q0.32
    function automatic logic [31:0] pow2_frac(input logic [2:0] b);
        case (b)
            3'd0:    pow2_frac = 32'd4283353945;
            3'd1:    pow2_frac = 32'd4271771997;
            3'd2:    pow2_frac = 32'd4248701965;
            3'd3:    pow2_frac = 32'd4202935003;
            3'd4:    pow2_frac = 32'd4112874793;
            3'd5:    pow2_frac = 32'd3938502376;
            3'd6:    pow2_frac = 32'd3611622603;
            default: pow2_frac = 32'd3037000500;
        endcase
    endfunction

    // floor(sqrt(d2) * 2^16) for squared tap distances up to 18
    function automatic logic [DIST_W-1:0] sqrt_q16(input logic [4:0] d2);
        case (d2)
            5'd0:    sqrt_q16 = 19'd0;
            5'd1:    sqrt_q16 = 19'd65536;
            5'd2:    sqrt_q16 = 19'd92681;
            5'd3:    sqrt_q16 = 19'd113511;
            5'd4:    sqrt_q16 = 19'd131072;
            5'd5:    sqrt_q16 = 19'd146542;
            5'd6:    sqrt_q16 = 19'd160529;
            5'd7:    sqrt_q16 = 19'd173391;
            5'd8:    sqrt_q16 = 19'd185363;
            5'd9:    sqrt_q16 = 19'd196608;
            5'd10:   sqrt_q16 = 19'd207243;
            5'd11:   sqrt_q16 = 19'd217358;
            5'd12:   sqrt_q16 = 19'd227023;
            5'd13:   sqrt_q16 = 19'd236293;
            5'd14:   sqrt_q16 = 19'd245213;
            5'd15:   sqrt_q16 = 19'd253819;
            5'd16:   sqrt_q16 = 19'd262144;
            5'd17:   sqrt_q16 = 19'd270211;
            5'd18:   sqrt_q16 = 19'd278045;
            default: sqrt_q16 = 19'd0;
        endcase
    endfunction

endpackage

`default_nettype wire

[rtl/core/bfr_ram.sv]
// ============================================================================
// bfr_ram: generic simple dual-port RAM
// One write port, one read port with the read data registered.
// ============================================================================
`default_nettype none

module bfr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/core/bilateral_filter_rgba.sv]
// ============================================================================
// bilateral_filter_rgba: streaming edge-preserving filter on RGBA pixels
// Line store of recent rows, per-tap weight pipeline, iterative normalizer.
// ============================================================================
// Pixels (func 0) arrive in raster order and are written to a line store of
// MAX_KERNEL rows; flush ticks (func 1) carry no pixel and drain the trailing
// rows. After each input beat the block emits, one at a time, up to four
// output pixels whose whole window has arrived; the ready line stays low
// meanwhile. Each output pixel takes a readiness check and one centre read
// with its wait, then one window tap per cycle out of the single read port of
// the line store, a drain of the 14-stage weight pipeline (luma distance,
// range and spatial terms, exp through eight power-of-two multiply stages),
// eight compare-subtract steps for the division by the weight sum and a load
// of the output register, which waits while the output is stalled. The line
// store needs no clearing pass after reset. Any configuration write restarts
// the frame; write configuration only while the block is idle.
`default_nettype none

module bilateral_filter_rgba
    import bfr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_func,
    input  wire logic [31:0] i_pixel_in,
    // output channel
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic      [31:0] o_pixel_out,
    output logic             o_last_of_frame,
    // configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    localparam int E_STAGES = 8;

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_CEN, S_CEN_WAIT, S_TAPS, S_DRAIN, S_DIV, S_OUT
    } t_state;

    t_state r_state;

    // configuration
    logic [10:0] r_image_width;
    logic [11:0] r_image_height;
    logic [2:0]  r_kernel_size;
    logic [31:0] r_range_coef;
    logic [31:0] r_spatial_coef;

    // frame position
    logic [COL_W-1:0]  r_in_col, r_out_col;
    logic [11:0]       r_in_row, r_out_row;
    logic [SLOT_W-1:0] r_in_slot, r_out_slot;
    logic [2:0]        r_out_count;

    // window walk
    logic signed [3:0] r_ti, r_tj;
    logic [23:0]       r_lc;
    logic [7:0]        r_alpha;

    // output register
    logic        r_out_valid;
    logic [31:0] r_pix_out;
    logic        r_last;

    // ------------------------------------------------------------------
    // Effective geometry
    // ------------------------------------------------------------------
    logic [10:0]      w_eff;
    logic [11:0]      h_eff;
    logic [COL_W-1:0] w_m1;
    logic [11:0]      h_m1;
    logic [2:0]       k_eff, half, jmax;

    always_comb begin
        if (r_image_width == 11'd0) begin
            w_eff = 11'd1;
        end else if (r_image_width > 11'(MAX_WIDTH)) begin
            w_eff = 11'(MAX_WIDTH);
        end else begin
            w_eff = r_image_width;
        end
        h_eff = (r_image_height == 12'd0) ? 12'd1 : r_image_height;
        k_eff = (r_kernel_size == 3'd0) ? 3'd1 : r_kernel_size;
        w_m1  = COL_W'(w_eff - 11'd1);
        h_m1  = h_eff - 12'd1;
        half  = k_eff >> 1;
        jmax  = k_eff[0] ? half : half - 3'd1;
    end

    // An output is ready once the last pixel of its clamped window arrived.
    logic [12:0]      ry_sum;
    logic [10:0]      cx_sum;
    logic [11:0]      ry;
    logic [COL_W-1:0] cx;
    logic             out_ready;
    logic             is_last;

    always_comb begin
        ry_sum    = {1'b0, r_out_row} + 13'(jmax);
        cx_sum    = {1'b0, r_out_col} + 11'(jmax);
        ry        = (ry_sum > {1'b0, h_m1}) ? h_m1 : ry_sum[11:0];
        cx        = (cx_sum > {1'b0, w_m1}) ? w_m1 : cx_sum[COL_W-1:0];
        out_ready = (r_in_row >= h_eff) || (r_in_row > ry)
                 || ((r_in_row == ry) && (r_in_col > cx));
        is_last   = (r_out_col >= w_m1) && (r_out_row >= h_m1);
    end

    // ------------------------------------------------------------------
    // Tap address: clamp the coordinates, wrap the row slot
    // ------------------------------------------------------------------
    logic signed [11:0] pxs;
    logic signed [13:0] pys, dys;
    logic [COL_W-1:0]   px;
    logic [11:0]        py;
    logic signed [3:0]  dy4;
    logic signed [7:0]  ti8, dy8;
    logic [4:0]         tap_d2;
    logic signed [4:0]  slot_s;
    logic [SLOT_W-1:0]  tap_slot;
    logic [ADDR_W-1:0]  tap_addr, cen_addr, wr_addr, rd_addr;
    logic signed [3:0]  neg_half;

    always_comb begin
        neg_half = -$signed({1'b0, half});
        pxs = $signed({2'b00, r_out_col}) + 12'(r_ti);
        pys = $signed({2'b00, r_out_row}) + 14'(r_tj);
        if (pxs < 12'sd0) begin
            px = '0;
        end else if (pxs > $signed({2'b00, w_m1})) begin
            px = w_m1;
        end else begin
            px = pxs[COL_W-1:0];
        end
        if (pys < 14'sd0) begin
            py = '0;
        end else if (pys > $signed({2'b00, h_m1})) begin
            py = h_m1;
        end else begin
            py = pys[11:0];
        end
        dys    = $signed({2'b00, py}) - $signed({2'b00, r_out_row});
        dy4    = dys[3:0];
        ti8    = 8'(r_ti);
        dy8    = 8'(dy4);
        tap_d2 = 5'(ti8 * ti8) + 5'(dy8 * dy8);
        slot_s = $signed({2'b00, r_out_slot}) + 5'(dy4);
        if (slot_s < 5'sd0) begin
            slot_s = slot_s + 5'(MAX_KERNEL);
        end else if (slot_s >= 5'(MAX_KERNEL)) begin
            slot_s = slot_s - 5'(MAX_KERNEL);
        end
        tap_slot = SLOT_W'(slot_s);
        tap_addr = ADDR_W'(tap_slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(px);
        cen_addr = ADDR_W'(r_out_slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(r_out_col);
        wr_addr  = ADDR_W'(r_in_slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(r_in_col);
        rd_addr  = (r_state == S_CEN) ? cen_addr : tap_addr;
    end

    // ------------------------------------------------------------------
    // Line store
    // ------------------------------------------------------------------
    logic        in_beat;
    logic        store_we;
    logic [31:0] rd_data;

    assign in_beat  = i_valid && o_ready;
    assign store_we = in_beat && !i_func && (r_in_row < h_eff);

    bfr_ram #(
        .WIDTH (32),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (wr_addr),
        .i_wdata (i_pixel_in),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // ------------------------------------------------------------------
    // Weight pipeline: one tap enters per cycle
    // ------------------------------------------------------------------
    logic               r_v0, r_va, r_vb, r_vc, r_vd, r_vf;
    logic [4:0]         r_d2_0, r_a_d2;
    logic [15:0]        r_a_dl;
    logic [23:0]        r_a_rgb, r_b_rgb, r_c_rgb, r_d_rgb, r_f_rgb;
    logic [31:0]        r_b_dl2;
    logic [34:0]        r_b_plo, r_b_phi;
    logic [31:0]        r_c_rt;
    logic [26:0]        r_c_st;
    logic [33:0]        r_d_t;
    logic [16:0]        r_f_wt;
    logic               r_e_v   [E_STAGES];
    logic [32:0]        r_e_acc [E_STAGES];
    logic [7:0]         r_e_f   [E_STAGES];
    logic [4:0]         r_e_n   [E_STAGES];
    logic               r_e_z   [E_STAGES];
    logic [23:0]        r_e_rgb [E_STAGES];

    logic [23:0]       luma;
    logic [15:0]       dl;
    logic [DIST_W-1:0] tap_dist;
    logic [63:0]       rt_prod;
    logic [50:0]       st_prod;
    logic [32:0]       e_sum;
    logic [49:0]       t_prod;
    logic [17:0]       t_n;
    logic              busy;
    logic              e_busy;

    always_comb begin
        luma = 24'(LUMA_R * 17'(rd_data[7:0]))
             + 24'(25'(LUMA_G) * 25'(rd_data[15:8]))
             + 24'(LUMA_B * 17'(rd_data[23:16]));
        dl   = (luma > r_lc) ? 16'((luma - r_lc) >> 8) : 16'((r_lc - luma) >> 8);
        tap_dist = sqrt_q16(r_a_d2);
        rt_prod = 64'(r_b_dl2) * 64'(r_range_coef);
        st_prod = (51'(r_b_phi) << 16) + 51'(r_b_plo);
        e_sum   = 33'(r_c_st) + 33'(r_c_rt);
        t_prod  = 50'(e_sum) * 50'(LOG2E_Q16);
        t_n     = r_d_t[33:16];
        e_busy  = 1'b0;
        for (int s = 0; s < E_STAGES; s++) begin
            e_busy = e_busy | r_e_v[s];
        end
        busy = r_v0 | r_va | r_vb | r_vc | r_vd | e_busy | r_vf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_vf <= 1'b0;
            for (int s = 0; s < E_STAGES; s++) begin
                r_e_v[s] <= 1'b0;
            end
        end else begin
            r_v0 <= (r_state == S_TAPS);
            r_va <= r_v0;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
            r_e_v[0] <= r_vd;
            for (int s = 1; s < E_STAGES; s++) begin
                r_e_v[s] <= r_e_v[s-1];
            end
            r_vf <= r_e_v[E_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        // tap read in flight
        r_d2_0  <= tap_d2;
        // luma distance
        r_a_d2  <= r_d2_0;
        r_a_dl  <= dl;
        r_a_rgb <= rd_data[23:0];
        // squares and spatial partial products
        r_b_dl2 <= 32'(r_a_dl) * 32'(r_a_dl);
        r_b_plo <= 35'(tap_dist) * 35'(r_spatial_coef[15:0]);
        r_b_phi <= 35'(tap_dist) * 35'(r_spatial_coef[31:16]);
        r_b_rgb <= r_a_rgb;
        // range and spatial terms
        r_c_rt  <= rt_prod[63:32];
        r_c_st  <= st_prod[50:24];
        r_c_rgb <= r_b_rgb;
        // exponent in log2 units
        r_d_t   <= t_prod[49:16];
        r_d_rgb <= r_c_rgb;
        // fractional power of two, one bit per stage, MSB first
        r_e_acc[0] <= r_d_t[15] ? {1'b0, pow2_frac(3'd7)} : 33'h1_0000_0000;
        r_e_f[0]   <= r_d_t[15:8];
        r_e_n[0]   <= t_n[4:0];
        r_e_z[0]   <= (t_n > 18'd16);
        r_e_rgb[0] <= r_d_rgb;
        for (int s = 1; s < E_STAGES; s++) begin
            if (r_e_f[s-1][E_STAGES-1-s]) begin
                r_e_acc[s] <= 33'((65'(r_e_acc[s-1])
                            * 65'(pow2_frac(3'(E_STAGES-1-s)))) >> 32);
            end else begin
                r_e_acc[s] <= r_e_acc[s-1];
            end
            r_e_f[s]   <= r_e_f[s-1];
            r_e_n[s]   <= r_e_n[s-1];
            r_e_z[s]   <= r_e_z[s-1];
            r_e_rgb[s] <= r_e_rgb[s-1];
        end
        // integer part of the exponent
        r_f_wt  <= r_e_z[E_STAGES-1] ? 17'd0
                 : 17'(r_e_acc[E_STAGES-1] >> (6'd16 + 6'(r_e_n[E_STAGES-1])));
        r_f_rgb <= r_e_rgb[E_STAGES-1];
    end

    // ------------------------------------------------------------------
    // Accumulate, then divide in place by the weight sum
    // ------------------------------------------------------------------
    logic [SUM_W-1:0] r_sum [3];
    logic [WS_W-1:0]  r_wsum;
    logic [7:0]       r_q   [3];
    logic [2:0]       r_bit;
    logic [SUM_W-1:0] div_cand;

    assign div_cand = SUM_W'(r_wsum) << r_bit;

    always_ff @(posedge i_clk) begin
        if (r_state == S_CEN_WAIT) begin
            r_wsum <= '0;
            for (int c = 0; c < 3; c++) begin
                r_sum[c] <= '0;
                r_q[c]   <= '0;
            end
        end else if (r_vf) begin
            r_wsum <= r_wsum + WS_W'(r_f_wt);
            for (int c = 0; c < 3; c++) begin
                r_sum[c] <= r_sum[c] + SUM_W'(25'(r_f_wt) * 25'(r_f_rgb[8*c +: 8]));
            end
        end else if (r_state == S_DIV) begin
            // the weighted mean never exceeds 255: eight quotient bits suffice
            for (int c = 0; c < 3; c++) begin
                if (r_sum[c] >= div_cand) begin
                    r_sum[c]     <= r_sum[c] - div_cand;
                    r_q[c][r_bit] <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer, counters, configuration and output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_image_width  <= 11'd1024;
            r_image_height <= 12'd1;
            r_kernel_size  <= 3'd3;
            r_range_coef   <= 32'h8000_0000;
            r_spatial_coef <= 32'h0100_0000;
            r_in_col       <= '0;
            r_in_row       <= '0;
            r_in_slot      <= '0;
            r_out_col      <= '0;
            r_out_row      <= '0;
            r_out_slot     <= '0;
            r_out_count    <= '0;
            r_out_valid    <= 1'b0;
            r_ti           <= '0;
            r_tj           <= '0;
            r_bit          <= '0;
        end else begin
            // drop the output beat once taken, unless a new one replaces it
            if (r_out_valid && i_ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_beat) begin
                        if (store_we) begin
                            if (r_in_col >= w_m1) begin
                                r_in_col  <= '0;
                                r_in_row  <= r_in_row + 12'd1;
                                r_in_slot <= (r_in_slot == SLOT_W'(MAX_KERNEL - 1))
                                           ? '0 : r_in_slot + SLOT_W'(1);
                            end else begin
                                r_in_col <= r_in_col + COL_W'(1);
                            end
                        end
                        r_out_count <= '0;
                        r_state     <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if ((r_out_count < 3'(OUT_CAP)) && out_ready) begin
                        r_state <= S_CEN;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_CEN: begin
                    r_state <= S_CEN_WAIT;
                end
                S_CEN_WAIT: begin
                    r_lc    <= luma;
                    r_alpha <= rd_data[31:24];
                    r_ti    <= neg_half;
                    r_tj    <= neg_half;
                    r_state <= S_TAPS;
                end
                S_TAPS: begin
                    if (r_ti == $signed({1'b0, jmax})) begin
                        r_ti <= neg_half;
                        if (r_tj == $signed({1'b0, jmax})) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_tj <= r_tj + 4'sd1;
                        end
                    end else begin
                        r_ti <= r_ti + 4'sd1;
                    end
                end
                S_DRAIN: begin
                    if (!busy) begin
                        r_bit   <= 3'd7;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_bit == 3'd0) begin
                        r_state <= S_OUT;
                    end else begin
                        r_bit <= r_bit - 3'd1;
                    end
                end
                S_OUT: begin
                    // hold the result until the output register frees
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_pix_out   <= {r_alpha, r_q[2], r_q[1], r_q[0]};
                        r_last      <= is_last;
                        if (is_last) begin
                            r_in_col   <= '0;
                            r_in_row   <= '0;
                            r_in_slot  <= '0;
                            r_out_col  <= '0;
                            r_out_row  <= '0;
                            r_out_slot <= '0;
                            r_state    <= S_IDLE;
                        end else begin
                            if (r_out_col >= w_m1) begin
                                r_out_col  <= '0;
                                r_out_row  <= r_out_row + 12'd1;
                                r_out_slot <= (r_out_slot == SLOT_W'(MAX_KERNEL - 1))
                                            ? '0 : r_out_slot + SLOT_W'(1);
                            end else begin
                                r_out_col <= r_out_col + COL_W'(1);
                            end
                            r_out_count <= r_out_count + 3'd1;
                            r_state     <= S_CHECK;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // configuration beat: write the register and restart the frame
            if (i_cfg_valid && o_cfg_ready && (i_cfg_index <= CFG_SPATIAL)) begin
                case (i_cfg_index)
                    CFG_WIDTH:   r_image_width  <= i_cfg_data[10:0];
                    CFG_HEIGHT:  r_image_height <= i_cfg_data[11:0];
                    CFG_KERNEL:  r_kernel_size  <= i_cfg_data[2:0];
                    CFG_RANGE:   r_range_coef   <= i_cfg_data;
                    CFG_SPATIAL: r_spatial_coef <= i_cfg_data;
                    default: begin
                    end
                endcase
                r_in_col   <= '0;
                r_in_row   <= '0;
                r_in_slot  <= '0;
                r_out_col  <= '0;
                r_out_row  <= '0;
                r_out_slot <= '0;
            end
        end
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_valid         = r_out_valid;
    assign o_pixel_out     = r_pix_out;
    assign o_last_of_frame = r_last;

endmodule

`default_nettype wire

[tb/tb_bilateral_filter_rgba.sv]
// ============================================================================
// tb_bilateral_filter_rgba: self-checking bench of the bilateral filter
// Drives pixel and flush beats with random idling on both channels, predicts
// every filtered pixel with a bit-exact software filter in a scoreboard class
// and compares each output beat in order. Configuration is rewritten between
// phases while the block is idle.
// ============================================================================
`default_nettype none

module tb_bilateral_filter_rgba;
    import bfr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] pixel;
        logic        last;
    } t_filt_out;

    // bit-exact software filter plus the queue of pixels it still expects
    class filter_scoreboard;
        logic [31:0] rows [STORE_DEPTH];
        int unsigned in_col, in_row, out_col, out_row;
        int unsigned width_reg, height_reg, ksize_reg;
        logic [31:0] range_reg, spatial_reg;
        t_filt_out   pending[$];
        int          errors;

        function new();
            foreach (rows[i]) rows[i] = '0;
            width_reg = 1024; height_reg = 1; ksize_reg = 3;
            range_reg = 32'h8000_0000; spatial_reg = 32'h0100_0000;
            errors = 0;
            restart();
        endfunction

        function void restart();
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                CFG_WIDTH:   width_reg   = data[10:0];
                CFG_HEIGHT:  height_reg  = data[11:0];
                CFG_KERNEL:  ksize_reg   = data[2:0];
                CFG_RANGE:   range_reg   = data;
                CFG_SPATIAL: spatial_reg = data;
                default:     return;
            endcase
            restart();
        endfunction

        function int unsigned w_eff();
            if (width_reg < 1) return 1;
            return (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
        endfunction

        function int unsigned h_eff();
            return (height_reg < 1) ? 1 : height_reg;
        endfunction

        function int unsigned k_eff();
            if (ksize_reg < 1) return 1;
            return (ksize_reg > MAX_KERNEL) ? MAX_KERNEL : ksize_reg;
        endfunction

        function logic [63:0] luma(logic [31:0] p);
            return 64'(p[7:0]) * 19595 + 64'(p[15:8]) * 38470 + 64'(p[23:16]) * 7471;
        endfunction

        function logic [63:0] root_q32(logic [63:0] v);
            logic [63:0] r, b;
            r = 0; b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b); r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function logic [63:0] exp_weight(logic [63:0] e);
            logic [63:0] t, n, acc;
            logic [7:0]  f;
            logic [31:0] p2 [8];
            p2 = '{32'd4283353945, 32'd4271771997, 32'd4248701965, 32'd4202935003,
                   32'd4112874793, 32'd3938502376, 32'd3611622603, 32'd3037000500};
            t = (e * 94548) >> 16;
            n = t >> 16;
            f = t[15:8];
            acc = 64'd1 << 32;
            if (n > 16) return 0;
            for (int b = 7; b >= 0; b--)
                if (f[b]) acc = (acc * p2[b]) >> 32;
            return acc >> (16 + n);
        endfunction

        function logic [31:0] fetch(int px, int py);
            return rows[(py % MAX_KERNEL) * MAX_WIDTH + px];
        endfunction

        function logic [31:0] filter_pixel(int unsigned w, int unsigned h, int unsigned k);
            int          half, jmax, x, y, py, px, dy;
            logic [31:0] ctr, p, res;
            logic [63:0] lc, l, dl, rt, st, wt, wsum, q;
            logic [63:0] sum [3];
            half = k / 2;
            jmax = k[0] ? half : half - 1;
            x = out_col; y = out_row;
            ctr = fetch(x, y);
            lc = luma(ctr);
            sum = '{0, 0, 0}; wsum = 0;
            res = {ctr[31:24], 24'd0};
            for (int j = -half; j <= jmax; j++) begin
                py = y + j;
                if (py < 0) py = 0;
                if (py > int'(h) - 1) py = h - 1;
                for (int i = -half; i <= jmax; i++) begin
                    px = x + i;
                    if (px < 0) px = 0;
                    if (px > int'(w) - 1) px = w - 1;
                    dy = py - y;
                    p = fetch(px, py);
                    l = luma(p);
                    dl = ((l > lc) ? l - lc : lc - l) >> 8;
                    rt = (dl * dl * range_reg) >> 32;
                    st = (root_q32(64'(i * i + dy * dy) << 32) * spatial_reg) >> 24;
                    wt = exp_weight(st + rt);
                    wsum += wt;
                    for (int c = 0; c < 3; c++) sum[c] += wt * p[8*c +: 8];
                end
            end
            for (int c = 0; c < 3; c++) begin
                q = (wsum != 0) ? sum[c] / wsum : 0;
                if (q > 255) q = 255;
                res[8*c +: 8] = q[7:0];
            end
            return res;
        endfunction

        function bit window_ready(int unsigned w, int unsigned h, int unsigned jmax);
            int unsigned ry, cx;
            ry = out_row + jmax; cx = out_col + jmax;
            if (in_row >= h) return 1;
            if (ry > h - 1) ry = h - 1;
            if (cx > w - 1) cx = w - 1;
            return (in_row > ry) || (in_row == ry && in_col > cx);
        endfunction

        // note an accepted input beat and queue every pixel it releases
        function void note_input(logic flush, logic [31:0] pixel);
            int unsigned w, h, k, jmax, cnt;
            bit          last;
            w = w_eff(); h = h_eff(); k = k_eff();
            jmax = k[0] ? k / 2 : k / 2 - 1;
            cnt = 0;
            if (!flush && in_row < h) begin
                rows[(in_row % MAX_KERNEL) * MAX_WIDTH + in_col] = pixel;
                if (in_col + 1 >= w) begin
                    in_col = 0; in_row++;
                end else begin
                    in_col++;
                end
            end
            while (cnt < OUT_CAP && window_ready(w, h, jmax)) begin
                last = (out_col + 1 >= w) && (out_row + 1 >= h);
                pending.push_back('{filter_pixel(w, h, k), last});
                cnt++;
                if (last) begin
                    restart();
                    break;
                end
                if (out_col + 1 >= w) begin
                    out_col = 0; out_row++;
                end else begin
                    out_col++;
                end
            end
        endfunction

        // compare one output beat with the oldest expected pixel
        function void check_output(logic [31:0] pixel, logic last);
            t_filt_out exp_px;
            if (pending.size() == 0) begin
                $display("%0t: unexpected pixel %h last %0b", $realtime, pixel, last);
                errors++;
                return;
            end
            exp_px = pending.pop_front();
            if (pixel !== exp_px.pixel) begin
                $display("%0t: pixel_out expected %h actual %h",
                         $realtime, exp_px.pixel, pixel);
                errors++;
            end
            if (last !== exp_px.last) begin
                $display("%0t: last_of_frame expected %0b actual %0b",
                         $realtime, exp_px.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0, in_func = 1'b0;
    logic [31:0] in_pixel = '0;
    logic        out_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [2:0]  cfg_index = CFG_WIDTH;
    logic [31:0] cfg_data = '0;
    wire         in_ready, out_valid, out_last, cfg_ready;
    wire  [31:0] out_pixel;

    int unsigned send_idle_pct = 0, recv_idle_pct = 0;
    filter_scoreboard sb;

    always #2 clk = ~clk;

    bilateral_filter_rgba i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (in_valid),
        .o_ready         (in_ready),
        .i_func          (in_func),
        .i_pixel_in      (in_pixel),
        .o_valid         (out_valid),
        .i_ready         (out_ready),
        .o_pixel_out     (out_pixel),
        .o_last_of_frame (out_last),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    // receiver: stall at random, check every beat that completes
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            sb.check_output(out_pixel, out_last);
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // send one beat; idle first at random, hold valid until accepted
    task automatic send_beat(input logic flush, input logic [31:0] pixel);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_func  <= flush;
        in_pixel <= pixel;
        do @(posedge clk); while (!in_ready);
        sb.note_input(flush, pixel);
    endtask

    // wait out every expected pixel, then the worst-case output latency
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [2:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task automatic set_frame(input int w, input int h, input int k,
                             input logic [31:0] rc, input logic [31:0] sc);
        drain();
        write_cfg(CFG_WIDTH, w);
        write_cfg(CFG_HEIGHT, h);
        write_cfg(CFG_KERNEL, k);
        write_cfg(CFG_RANGE, rc);
        write_cfg(CFG_SPATIAL, sc);
        cfg_valid <= 1'b0;
    endtask

    // one whole frame of random content, then flush ticks to drain the tail
    task automatic run_frame(input int npix);
        for (int n = 0; n < npix; n++) send_beat(1'b0, $urandom());
        repeat (4) send_beat(1'b1, $urandom());
    endtask

    initial begin
        #200000000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset setting is a 1024x1 row; use a small frame instead
        send_idle_pct = 28; recv_idle_pct = 51;
        set_frame(4, 3, 3, 32'h8000_0000, 32'h0100_0000);
        send_beat(1'b1, 32'h0);              // early flush: nothing ready yet
        send_beat(1'b0, 32'h0000_0000);
        send_beat(1'b0, 32'hFFFF_FFFF);
        send_beat(1'b0, 32'h00FF_00FF);
        send_beat(1'b0, 32'hFF00_FF00);
        for (int n = 0; n < 8; n++) send_beat(1'b0, {8'(n * 37), 24'h80_40_20 ^ 24'(n)});
        send_beat(1'b0, 32'hDEAD_BEEF);      // surplus pixel after frame end
        repeat (3) send_beat(1'b1, 32'hFFFF_FFFF);

        // extremes: single pixel with kernel 0 (clamps to 1), zero coefficients
        set_frame(1, 1, 0, 32'h0, 32'h0);
        send_beat(1'b0, 32'h1234_5678);
        set_frame(2047, 1, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // width clamps to the line store limit; no pixels are sent with it
        set_frame(3, 0, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_frame(3);

        // random phases with random settings, kernel sizes 1 to 7
        for (int ph = 0; ph < 9; ph++) begin
            if (ph == 3) begin
                send_idle_pct = 51; recv_idle_pct = 28;
            end else if (ph == 6) begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            set_frame($urandom_range(1, 5), $urandom_range(1, 4), $urandom_range(1, 7),
                      $urandom(), $urandom() >> $urandom_range(0, 31));
            run_frame(sb.w_eff() * sb.h_eff());
        end

        // one wide row at maximum width with a tiny kernel
        set_frame(1024, 1, 1, 32'h8000_0000, 32'h0100_0000);
        send_idle_pct = 0;
        run_frame(20);                       // partial row; outputs trail inputs

        drain();
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

`default_nettype wire
